### rtl/stsa_pkg.sv
// Shared types and constants for the sensor timestamp aligner.
// Used by the channel interfaces and every rtl module of the block.
`timescale 1ns / 1ps

package stsa_pkg;

  // field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLOTF_W = 2;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned OFF_W   = 64;

  // slot count default
  localparam int unsigned SLOT_COUNT_DEF = 4;

  // ns to us conversion factor
  localparam int unsigned NS_PER_US  = 1000;

  // result queue depth, also the number of outstanding beats allowed
  localparam int unsigned FIFO_DEPTH = 16;

  localparam logic [SHIFT_W-1:0] DRIFT_SHIFT_RESET = SHIFT_W'(10);
  localparam logic [TIME_W-1:0]  TIME_MAX          = {TIME_W{1'b1}};

  // sensor kinds
  localparam logic [KIND_W-1:0] KIND_ACCEL    = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_GYRO     = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_MAG      = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_PRESSURE = KIND_W'(3);

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNKNOWN = 2'd1,
    STATUS_NONPOS  = 2'd2,
    STATUS_ORDER   = 2'd3
  } status_e;

  // input beat as captured at the port
  typedef struct packed {
    logic [KIND_W-1:0] sensor_kind;
    logic [TIME_W-1:0] event_time_ns;
    logic [TIME_W-1:0] local_time_us;
    logic [VAL_W-1:0]  value_x;
    logic [VAL_W-1:0]  value_y;
    logic [VAL_W-1:0]  value_z;
  } in_beat_t;

  // beat after the ns to us conversion
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] ev_us;
    logic [TIME_W-1:0] now_us;
    logic [VAL_W-1:0]  vx;
    logic [VAL_W-1:0]  vy;
    logic [VAL_W-1:0]  vz;
  } work_t;

  // result beat
  typedef struct packed {
    status_e            status;
    logic [SLOTF_W-1:0] slot;
    logic [TIME_W-1:0]  mapped_time_us;
    logic [VAL_W-1:0]   out_forward;
    logic [VAL_W-1:0]   out_right;
    logic [VAL_W-1:0]   out_down;
  } out_beat_t;

  // kinds above pressure are not tracked
  function automatic logic kind_known(input logic [KIND_W-1:0] kind);
    return kind <= KIND_PRESSURE;
  endfunction

endpackage

### rtl/stsa_in_if.sv
// Input event channel: valid/ready handshake with the sensor event fields.
// Depends on stsa_pkg for field widths.
`timescale 1ns / 1ps

interface stsa_in_if;
  logic                               valid;
  logic                               ready;
  logic [stsa_pkg::KIND_W-1:0]        sensor_kind;
  logic [stsa_pkg::TIME_W-1:0]        event_time_ns;
  logic [stsa_pkg::TIME_W-1:0]        local_time_us;
  logic signed [stsa_pkg::VAL_W-1:0]  value_x;
  logic signed [stsa_pkg::VAL_W-1:0]  value_y;
  logic signed [stsa_pkg::VAL_W-1:0]  value_z;

  modport source (
    output valid, sensor_kind, event_time_ns, local_time_us, value_x, value_y, value_z,
    input  ready
  );

  modport sink (
    input  valid, sensor_kind, event_time_ns, local_time_us, value_x, value_y, value_z,
    output ready
  );
endinterface

### rtl/stsa_out_if.sv
// Result channel: valid/ready handshake with the aligned event fields.
// Depends on stsa_pkg for field widths.
`timescale 1ns / 1ps

interface stsa_out_if;
  logic                               valid;
  logic                               ready;
  logic [stsa_pkg::STAT_W-1:0]        status;
  logic [stsa_pkg::SLOTF_W-1:0]       slot;
  logic [stsa_pkg::TIME_W-1:0]        mapped_time_us;
  logic signed [stsa_pkg::VAL_W-1:0]  out_forward;
  logic signed [stsa_pkg::VAL_W-1:0]  out_right;
  logic signed [stsa_pkg::VAL_W-1:0]  out_down;

  modport source (
    output valid, status, slot, mapped_time_us, out_forward, out_right, out_down,
    input  ready
  );

  modport sink (
    input  valid, status, slot, mapped_time_us, out_forward, out_right, out_down,
    output ready
  );
endinterface

### rtl/stsa_div1000.sv
// Pipelined ns to us conversion: shift out the factor 8 of 1000, then multiply
// by the reciprocal of 125 in 32-bit partial products over three stages.
// Carries the rest of the beat alongside. Depends on stsa_pkg.
`timescale 1ns / 1ps

module stsa_div1000 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  stsa_pkg::in_beat_t beat_i,
  output logic               valid_o,
  output stsa_pkg::work_t    work_o
);

  localparam int unsigned TW     = stsa_pkg::TIME_W;
  // 1000 = 8 * 125
  localparam int unsigned PRE_SH = 3;
  localparam int unsigned ODD    = stsa_pkg::NS_PER_US >> PRE_SH;
  // shifted dividend width and reciprocal scale, exact for every dividend
  localparam int unsigned N_W    = TW - PRE_SH;
  localparam int unsigned RCP_SH = N_W + 7;
  localparam int unsigned RCP_W  = 61;
  localparam int unsigned SUM_W  = TW + RCP_SH - 32;

  localparam logic [127:0] RCP_FULL =
    ((128'd1 << RCP_SH) + 128'(ODD - 1)) / 128'(ODD);
  localparam logic [31:0]       RCP_LO = RCP_FULL[31:0];
  localparam logic [RCP_W-33:0] RCP_HI = RCP_FULL[RCP_W-1:32];

  logic [2:0]        vld_q;
  stsa_pkg::work_t   w_in;
  stsa_pkg::work_t   w1_q, w2_q, w3_q, w3_d;
  logic [N_W-1:0]    n;
  logic [63:0]       p_ll, p_lh, p_hl, p_hh;
  logic [63:0]       p_ll_q, p_lh_q, p_hl_q, p_hh_q;
  logic [63:0]       mid, mid_q, p_hh2_q;
  logic [SUM_W-1:0]  top;

  // beat fields carried along, us time filled at the end
  always_comb begin
    w_in.kind   = beat_i.sensor_kind;
    w_in.ev_us  = '0;
    w_in.now_us = beat_i.local_time_us;
    w_in.vx     = beat_i.value_x;
    w_in.vy     = beat_i.value_y;
    w_in.vz     = beat_i.value_z;
  end

  // partial products of the shifted dividend and the reciprocal
  assign n    = beat_i.event_time_ns[TW-1:PRE_SH];
  assign p_ll = 64'(n[31:0]) * 64'(RCP_LO);
  assign p_lh = 64'(n[31:0]) * 64'(RCP_HI);
  assign p_hl = 64'(n[N_W-1:32]) * 64'(RCP_LO);
  assign p_hh = 64'(n[N_W-1:32]) * 64'(RCP_HI);

  // middle column sum, then the upper column and the final shift
  assign mid  = 64'(p_ll_q[63:32]) + p_lh_q + p_hl_q;
  assign top  = (SUM_W'(p_hh2_q) << 32) + SUM_W'(mid_q);

  always_comb begin
    w3_d       = w2_q;
    w3_d.ev_us = top[SUM_W-1 -: TW];
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    p_ll_q  <= p_ll;
    p_lh_q  <= p_lh;
    p_hl_q  <= p_hl;
    p_hh_q  <= p_hh;
    w1_q    <= w_in;
    mid_q   <= mid;
    p_hh2_q <= p_hh_q;
    w2_q    <= w1_q;
    w3_q    <= w3_d;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign work_o  = w3_q;

endmodule

### rtl/stsa_off_stage.sv
// Per-slot offset tracking: offset memory read, update and write back with
// one-deep forwarding for back-to-back beats on a slot. Depends on stsa_pkg.
`timescale 1ns / 1ps

module stsa_off_stage #(
  parameter int unsigned SLOT_COUNT = stsa_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  stsa_pkg::work_t               work_i,
  input  logic [stsa_pkg::SHIFT_W-1:0]  drift_shift_i,
  output logic                          valid_o,
  output stsa_pkg::work_t               work_o,
  output logic [stsa_pkg::OFF_W-1:0]    offset_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned OW     = stsa_pkg::OFF_W;

  logic [OW-1:0]         off_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] off_vld_q;

  logic                  a_vld_q;
  stsa_pkg::work_t       a_work_q;
  logic [OW-1:0]         a_cand_q;
  logic [OW-1:0]         a_rd_q;

  logic                  fwd_vld_q;
  logic [SLOT_W-1:0]     fwd_slot_q;
  logic [OW-1:0]         fwd_off_q;

  logic                  b_vld_q;
  stsa_pkg::work_t       b_work_q;
  logic [OW-1:0]         b_off_q;

  logic                  in_known;
  logic [SLOT_W-1:0]     in_slot;
  logic [OW-1:0]         in_cand;
  logic                  a_known;
  logic [SLOT_W-1:0]     a_slot;
  logic                  a_wr;
  logic [OW-1:0]         off_cur;
  logic [OW-1:0]         off_diff;
  logic [OW-1:0]         off_new;
  logic                  adopt;

  // candidate offset is local minus remote, never out of signed range
  assign in_known = stsa_pkg::kind_known(work_i.kind);
  assign in_slot  = SLOT_W'(work_i.kind);
  assign in_cand  = {1'b0, work_i.now_us} - {1'b0, work_i.ev_us};

  // offset memory read, data lands with the beat in the update stage
  always_ff @(posedge clk_i) begin
    if (valid_i && in_known) begin
      a_rd_q <= off_mem[in_slot];
    end
  end

  // offset memory write back
  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      off_mem[a_slot] <= off_new;
    end
  end

  // update stage payload
  always_ff @(posedge clk_i) begin
    a_work_q  <= work_i;
    a_cand_q  <= in_cand;
    fwd_slot_q <= a_slot;
    fwd_off_q  <= off_new;
    b_work_q  <= a_work_q;
    b_off_q   <= off_new;
  end

  // offset update: adopt the first or a lower candidate, else drift up by a fraction
  assign a_known  = stsa_pkg::kind_known(a_work_q.kind);
  assign a_slot   = SLOT_W'(a_work_q.kind);
  assign a_wr     = a_vld_q && a_known;
  assign off_cur  = (fwd_vld_q && (fwd_slot_q == a_slot)) ? fwd_off_q : a_rd_q;
  assign off_diff = a_cand_q - off_cur;
  assign adopt    = !off_vld_q[a_slot] || ($signed(a_cand_q) < $signed(off_cur));
  assign off_new  = adopt ? a_cand_q : (off_cur + (off_diff >> drift_shift_i));

  // control and per-slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      fwd_vld_q <= 1'b0;
      off_vld_q <= '0;
    end else begin
      a_vld_q   <= valid_i;
      b_vld_q   <= a_vld_q;
      fwd_vld_q <= a_wr;
      if (a_wr) begin
        off_vld_q[a_slot] <= 1'b1;
      end
    end
  end

  assign valid_o  = b_vld_q;
  assign work_o   = b_work_q;
  assign offset_o = b_off_q;

endmodule

### rtl/stsa_ord_stage.sv
// Mapped time and ordering check: last-time memory read, compare and write
// back with one-deep forwarding; builds the result beat. Depends on stsa_pkg.
`timescale 1ns / 1ps

module stsa_ord_stage #(
  parameter int unsigned SLOT_COUNT = stsa_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  stsa_pkg::work_t             work_i,
  input  logic [stsa_pkg::OFF_W-1:0]  offset_i,
  output logic                        push_o,
  output stsa_pkg::out_beat_t         res_o
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned TW     = stsa_pkg::TIME_W;
  localparam int unsigned OW     = stsa_pkg::OFF_W;
  localparam int unsigned VW     = stsa_pkg::VAL_W;
  localparam int unsigned SUM_W  = OW + 2;

  logic [TW-1:0]         last_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] last_vld_q;

  logic                  c_vld_q;
  stsa_pkg::work_t       c_work_q;
  logic [TW-1:0]         c_mapped_q;
  logic                  c_nonpos_q;
  logic [TW-1:0]         c_rd_q;

  logic                  fwd_vld_q;
  logic [SLOT_W-1:0]     fwd_slot_q;
  logic [TW-1:0]         fwd_last_q;

  logic                  in_known;
  logic [SLOT_W-1:0]     in_slot;
  logic signed [SUM_W-1:0] sum;
  logic                  in_nonpos;
  logic                  in_sat;
  logic [TW-1:0]         in_mapped;

  logic                  c_known;
  logic [SLOT_W-1:0]     c_slot;
  logic [TW-1:0]         last_cur;
  stsa_pkg::status_e     c_status;
  logic                  c_wr;

  // saturating negate of a 32-bit word
  function automatic logic [VW-1:0] neg_sat(input logic [VW-1:0] w);
    if (w == {1'b1, {(VW-1){1'b0}}}) begin
      return {1'b0, {(VW-1){1'b1}}};
    end
    return -w;
  endfunction

  // mapped time = remote us plus signed offset, saturated to the time range
  assign in_known  = stsa_pkg::kind_known(work_i.kind);
  assign in_slot   = SLOT_W'(work_i.kind);
  assign sum       = $signed({{(SUM_W-TW){1'b0}}, work_i.ev_us})
                   + $signed({{(SUM_W-OW){offset_i[OW-1]}}, offset_i});
  assign in_nonpos = sum[SUM_W-1] || (sum == '0);
  assign in_sat    = !sum[SUM_W-1] && (|sum[SUM_W-2:TW]);
  assign in_mapped = in_nonpos ? '0 : (in_sat ? stsa_pkg::TIME_MAX : sum[TW-1:0]);

  // last-time memory read
  always_ff @(posedge clk_i) begin
    if (valid_i && in_known) begin
      c_rd_q <= last_mem[in_slot];
    end
  end

  // last-time memory write back
  always_ff @(posedge clk_i) begin
    if (c_wr) begin
      last_mem[c_slot] <= c_mapped_q;
    end
  end

  // check stage payload
  always_ff @(posedge clk_i) begin
    c_work_q   <= work_i;
    c_mapped_q <= in_mapped;
    c_nonpos_q <= in_nonpos;
    fwd_slot_q <= c_slot;
    fwd_last_q <= c_mapped_q;
  end

  // ordering check against the last accepted time of the slot
  assign c_known  = stsa_pkg::kind_known(c_work_q.kind);
  assign c_slot   = SLOT_W'(c_work_q.kind);
  assign last_cur = (fwd_vld_q && (fwd_slot_q == c_slot)) ? fwd_last_q
                  : (last_vld_q[c_slot] ? c_rd_q : '0);

  always_comb begin
    if (!c_known) begin
      c_status = stsa_pkg::STATUS_UNKNOWN;
    end else if (c_nonpos_q) begin
      c_status = stsa_pkg::STATUS_NONPOS;
    end else if (c_mapped_q <= last_cur) begin
      c_status = stsa_pkg::STATUS_ORDER;
    end else begin
      c_status = stsa_pkg::STATUS_OK;
    end
  end

  assign c_wr = c_vld_q && (c_status == stsa_pkg::STATUS_OK);

  // control and per-slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q    <= 1'b0;
      fwd_vld_q  <= 1'b0;
      last_vld_q <= '0;
    end else begin
      c_vld_q   <= valid_i;
      fwd_vld_q <= c_wr;
      if (c_wr) begin
        last_vld_q[c_slot] <= 1'b1;
      end
    end
  end

  // result beat, axes remapped to (y, x, -z), pressure passed on forward
  always_comb begin
    res_o.status         = c_status;
    res_o.slot           = c_known ? c_work_q.kind[stsa_pkg::SLOTF_W-1:0] : '0;
    res_o.mapped_time_us = '0;
    res_o.out_forward    = '0;
    res_o.out_right      = '0;
    res_o.out_down       = '0;
    if (c_status == stsa_pkg::STATUS_OK) begin
      res_o.mapped_time_us = c_mapped_q;
      if (c_work_q.kind == stsa_pkg::KIND_PRESSURE) begin
        res_o.out_forward = c_work_q.vx;
      end else begin
        res_o.out_forward = c_work_q.vy;
        res_o.out_right   = c_work_q.vx;
        res_o.out_down    = neg_sat(c_work_q.vz);
      end
    end
  end

  assign push_o = c_vld_q;

endmodule

### rtl/stsa_out_fifo.sv
// Result queue between the pipeline and the result channel; absorbs every
// beat in flight when the sink stalls. Depends on stsa_pkg and stsa_out_if.
`timescale 1ns / 1ps

module stsa_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  stsa_pkg::out_beat_t data_i,
  stsa_out_if.source          res_o
);

  localparam int unsigned DEPTH = stsa_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  stsa_pkg::out_beat_t fifo_q [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pop;
  stsa_pkg::out_beat_t head;

  assign pop  = res_o.valid && res_o.ready;
  assign head = fifo_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign res_o.valid          = cnt_q != '0;
  assign res_o.status         = head.status;
  assign res_o.slot           = head.slot;
  assign res_o.mapped_time_us = head.mapped_time_us;
  assign res_o.out_forward    = head.out_forward;
  assign res_o.out_right      = head.out_right;
  assign res_o.out_down       = head.out_down;

endmodule

### rtl/sensor_timestamp_aligner_core.sv
// Top level of the sensor timestamp aligner: divider pipeline, offset and
// ordering stages over per-slot memories, result queue and credit count.
// Depends on stsa_pkg, stsa_in_if, stsa_out_if and the stsa_* modules.
//
//   channel  | dir | handshake     | contents
//   evt_i    | in  | valid/ready   | kind, remote ns, local us, x/y/z words
//   res_o    | out | valid/ready   | status, slot, mapped us, forward/right/down
//   cfg      | in  | cfg_we_i      | drift_shift (5 bits)
//
// One beat per cycle is accepted while evt_i.ready is high; its result passes
// the divide-by-1000 pipeline, the offset memory read-modify-write stages,
// the last-time check register and the result queue before it is valid on
// res_o. Up to 16 beats may be outstanding: when the sink stalls, results
// collect in the 16-entry queue and evt_i.ready drops once 16 are
// outstanding. Reset clears the per-slot valid bits at once; there is no
// clearing pass.
`timescale 1ns / 1ps

module sensor_timestamp_aligner_core #(
  parameter int unsigned SLOT_COUNT = stsa_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  stsa_in_if.sink                      evt_i,
  stsa_out_if.source                   res_o,
  input  logic                         cfg_we_i,
  input  logic [stsa_pkg::SHIFT_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(stsa_pkg::FIFO_DEPTH + 1);

  logic [stsa_pkg::SHIFT_W-1:0] drift_shift_q;
  logic [CNT_W-1:0]             credit_q, credit_d;
  logic                         in_fire;
  logic                         out_fire;
  stsa_pkg::in_beat_t           in_beat;

  logic                         div_vld;
  stsa_pkg::work_t              div_work;
  logic                         off_vld;
  stsa_pkg::work_t              off_work;
  logic [stsa_pkg::OFF_W-1:0]   off_val;
  logic                         push;
  stsa_pkg::out_beat_t          push_beat;

  // drift shift register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drift_shift_q <= stsa_pkg::DRIFT_SHIFT_RESET;
    end else if (cfg_we_i) begin
      drift_shift_q <= cfg_wdata_i;
    end
  end

  // outstanding beat count, bounded by the queue depth
  assign evt_i.ready = credit_q < CNT_W'(stsa_pkg::FIFO_DEPTH);
  assign in_fire     = evt_i.valid && evt_i.ready;
  assign out_fire    = res_o.valid && res_o.ready;
  assign credit_d    = credit_q + CNT_W'(in_fire) - CNT_W'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  // input beat
  assign in_beat.sensor_kind   = evt_i.sensor_kind;
  assign in_beat.event_time_ns = evt_i.event_time_ns;
  assign in_beat.local_time_us = evt_i.local_time_us;
  assign in_beat.value_x       = evt_i.value_x;
  assign in_beat.value_y       = evt_i.value_y;
  assign in_beat.value_z       = evt_i.value_z;

  stsa_div1000 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_fire),
    .beat_i  (in_beat),
    .valid_o (div_vld),
    .work_o  (div_work)
  );

  stsa_off_stage #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_off (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (div_vld),
    .work_i        (div_work),
    .drift_shift_i (drift_shift_q),
    .valid_o       (off_vld),
    .work_o        (off_work),
    .offset_o      (off_val)
  );

  stsa_ord_stage #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ord (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (off_vld),
    .work_i   (off_work),
    .offset_i (off_val),
    .push_o   (push),
    .res_o    (push_beat)
  );

  stsa_out_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_beat),
    .res_o  (res_o)
  );

endmodule
